// ===== src/mwom_pkg.sv =====
// ----------------------------------------------------------------------------
// mwom_pkg
// Shared widths, codes, reset values and pipeline record types for the
// waveform oscillator mixer.
// ----------------------------------------------------------------------------
package mwom_pkg;

	// field widths
	localparam int SAMPLE_W   = 24;
	localparam int IDX_W      = 32;
	localparam int PERIOD_W   = 32;
	localparam int GAIN_W     = 16;
	localparam int WAVE_SEL_W = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// phase division: index scaled by 2^16 (or 2^18 plus period for the triangle)
	localparam int BASE_SHIFT = 16;
	localparam int TRI_SHIFT  = 18;
	localparam int NUM_W      = IDX_W + TRI_SHIFT + 1;
	localparam int DIV_W      = PERIOD_W + 2;
	localparam int FRAC_W     = 24;
	localparam int DIV_STAGES = NUM_W + FRAC_W;

	// scaling and mixing
	localparam int MAG_W       = FRAC_W;
	localparam int GAIN_PROD_W = 2 * GAIN_W;
	localparam int PROD_W      = MAG_W + GAIN_PROD_W;
	localparam int SCALE_SHIFT = 2 * (GAIN_W - 1) + (FRAC_W - 1) - (SAMPLE_W - 1);
	localparam int SC_W        = PROD_W + 1 - SCALE_SHIFT;
	localparam int SUM_W       = ((SC_W > SAMPLE_W) ? SC_W : SAMPLE_W) + 2;

	// waveform codes
	localparam logic [WAVE_SEL_W-1:0] WAVE_TRI    = 2'd0;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SAW    = 2'd1;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SQUARE = 2'd2;
	localparam logic [WAVE_SEL_W-1:0] WAVE_PULSE  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE = 3'd3;

	// reset values
	localparam logic [WAVE_SEL_W-1:0]  RST_WAVEFORM = WAVE_TRI;
	localparam logic [PERIOD_W-1:0]    RST_PERIOD   = 32'd6553600;
	localparam logic [GAIN_W-1:0]      RST_VOLUME   = 16'd32768;
	localparam logic [GAIN_W-1:0]      RST_ENVELOPE = 16'd32768;
	localparam logic [GAIN_PROD_W-1:0] RST_GAIN     =
		GAIN_PROD_W'(RST_VOLUME) * GAIN_PROD_W'(RST_ENVELOPE);

	// live configuration seen by the datapath
	typedef struct packed {
		logic [WAVE_SEL_W-1:0]  waveform;
		logic [PERIOD_W-1:0]    period;
		logic [GAIN_PROD_W-1:0] gain;
	} mwom_cfg_t;

	// record leaving the phase divider
	typedef struct packed {
		logic                vld;
		logic [FRAC_W-1:0]   frac;
		logic                half_lt;
		logic                fifth_lt;
		logic [SAMPLE_W-1:0] mix;
	} mwom_div_t;

endpackage

// ===== src/mwom_cfg.sv =====
// ----------------------------------------------------------------------------
// mwom_cfg
// Configuration register file with a registered volume times envelope gain.
// ----------------------------------------------------------------------------
module mwom_cfg import mwom_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output mwom_cfg_t             cfg
);

	logic [WAVE_SEL_W-1:0]  waveform_q;
	logic [PERIOD_W-1:0]    period_q;
	logic [GAIN_W-1:0]      volume_q;
	logic [GAIN_W-1:0]      envelope_q;
	logic [GAIN_PROD_W-1:0] gain_q;

	// take every write request at once
	assign cfg_ready = 1'b1;

	// write the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= RST_WAVEFORM;
			period_q   <= RST_PERIOD;
			volume_q   <= RST_VOLUME;
			envelope_q <= RST_ENVELOPE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WAVEFORM: waveform_q <= cfg_data[WAVE_SEL_W-1:0];
				REG_PERIOD:   period_q   <= cfg_data[PERIOD_W-1:0];
				REG_VOLUME:   volume_q   <= cfg_data[GAIN_W-1:0];
				REG_ENVELOPE: envelope_q <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// combine both gains once, ahead of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= RST_GAIN;
		end else begin
			gain_q <= GAIN_PROD_W'(volume_q) * GAIN_PROD_W'(envelope_q);
		end
	end

	assign cfg.waveform = waveform_q;
	assign cfg.period   = period_q;
	assign cfg.gain     = gain_q;

endmodule

// ===== src/mwom_div.sv =====
// ----------------------------------------------------------------------------
// mwom_div
// Phase divider: a restoring long division, one quotient bit per stage. The
// first NUM_W stages leave the phase remainder, the last FRAC_W stages give
// the fraction bits remainder * 2^24 / modulus.
// ----------------------------------------------------------------------------
module mwom_div import mwom_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  mwom_cfg_t           cfg,
	input  logic                in_vld,
	input  logic [IDX_W-1:0]    sample_index,
	input  logic [SAMPLE_W-1:0] mix_in,
	output mwom_div_t           dout
);

	logic                vld_s  [0:DIV_STAGES];
	logic [NUM_W-1:0]    num_s  [0:DIV_STAGES];
	logic [SAMPLE_W-1:0] mix_s  [0:DIV_STAGES];
	logic [DIV_W-1:0]    rem_s  [1:DIV_STAGES];
	logic [FRAC_W-1:0]   frac_s [1:DIV_STAGES];
	logic                half_s [1:DIV_STAGES];
	logic                fifth_s[1:DIV_STAGES];

	logic [DIV_W-1:0] divisor;
	logic             is_tri;

	// modulus: four periods for the quarter shifted triangle, else one
	assign is_tri  = (cfg.waveform == WAVE_TRI);
	assign divisor = is_tri ? {cfg.period, 2'b00} : DIV_W'(cfg.period);

	// valid bit of the numerator stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	// form the numerator
	always_ff @(posedge clk) begin
		if (en) begin
			mix_s[0] <= mix_in;
			if (is_tri) begin
				num_s[0] <= NUM_W'({sample_index, {TRI_SHIFT{1'b0}}}) + NUM_W'(cfg.period);
			end else begin
				num_s[0] <= NUM_W'({sample_index, {BASE_SHIFT{1'b0}}});
			end
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
		logic [DIV_W:0]   shifted;
		logic             ge;
		logic [DIV_W-1:0] rem_nxt;
		logic [DIV_W-1:0] rem_prev;
		logic [FRAC_W-1:0] frac_prev;
		logic             half_nxt;
		logic             fifth_nxt;

		if (k == 1) begin : g_first
			assign rem_prev  = '0;
			assign frac_prev = '0;
			assign half_nxt  = 1'b0;
			assign fifth_nxt = 1'b0;
		end else begin : g_rest
			assign rem_prev  = rem_s[k-1];
			assign frac_prev = frac_s[k-1];
			if (k == NUM_W + 1) begin : g_flags
				// remainder is final here: compare 2r and 5r with the modulus
				logic [DIV_W+2:0] five_r;
				assign five_r    = {3'b000, rem_prev} + {1'b0, rem_prev, 2'b00};
				assign half_nxt  = {rem_prev, 1'b0} < {1'b0, divisor};
				assign fifth_nxt = five_r < {3'b000, divisor};
			end else begin : g_pass
				assign half_nxt  = half_s[k-1];
				assign fifth_nxt = fifth_s[k-1];
			end
		end

		// shift in the next numerator bit and try the subtraction
		assign shifted = {rem_prev, num_s[k-1][NUM_W-1]};
		assign ge      = (shifted >= {1'b0, divisor});
		assign rem_nxt = ge ? DIV_W'(shifted - {1'b0, divisor}) : shifted[DIV_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]   <= rem_nxt;
				num_s[k]   <= {num_s[k-1][NUM_W-2:0], 1'b0};
				frac_s[k]  <= {frac_prev[FRAC_W-2:0], ge};
				half_s[k]  <= half_nxt;
				fifth_s[k] <= fifth_nxt;
				mix_s[k]   <= mix_s[k-1];
			end
		end
	end

	assign dout.vld      = vld_s[DIV_STAGES];
	assign dout.frac     = frac_s[DIV_STAGES];
	assign dout.half_lt  = half_s[DIV_STAGES];
	assign dout.fifth_lt = fifth_s[DIV_STAGES];
	assign dout.mix      = mix_s[DIV_STAGES];

endmodule

// ===== src/mwom_mix.sv =====
// ----------------------------------------------------------------------------
// mwom_mix
// Wave shaping, gain multiply, rounding and saturating mix, four stages.
// ----------------------------------------------------------------------------
module mwom_mix import mwom_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  mwom_cfg_t           cfg,
	input  mwom_div_t           din,
	output logic                vld,
	output logic [SAMPLE_W-1:0] mix_out
);

	localparam logic [FRAC_W-1:0] HALF    = {1'b1, {(FRAC_W-1){1'b0}}};
	localparam logic [FRAC_W-1:0] QUARTER = {2'b01, {(FRAC_W-2){1'b0}}};
	localparam logic [PROD_W:0]   RND     = (PROD_W+1)'(1) << (SCALE_SHIFT - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic                neg_s1, neg_s2, neg_s3;
	logic [MAG_W-1:0]    mag_s1;
	logic [PROD_W-1:0]   prod_s2;
	logic [SC_W-1:0]     sc_s3;
	logic [SAMPLE_W-1:0] mix_s1, mix_s2, mix_s3, mix_s4;

	logic              mod_zero;
	logic [FRAC_W-1:0] f;
	logic [FRAC_W-1:0] fold;
	logic              neg_nxt;
	logic [MAG_W-1:0]  mag_nxt;

	logic [PROD_W:0]         rnd_sum;
	logic [SC_W-1:0]         sc_nxt;
	logic signed [SUM_W-1:0] mix_x;
	logic signed [SUM_W-1:0] add_x;
	logic signed [SUM_W-1:0] sum;
	logic [SAMPLE_W-1:0]     sat_nxt;

	// a zero modulus reads as phase zero
	assign mod_zero = (cfg.period == '0);
	assign f        = mod_zero ? '0 : din.frac;
	assign fold     = (f >= HALF) ? FRAC_W'(f - HALF) : FRAC_W'(HALF - f);

	// shape the wave as sign and magnitude
	always_comb begin
		neg_nxt = 1'b0;
		mag_nxt = '0;
		case (cfg.waveform)
			WAVE_TRI: begin
				if (fold >= QUARTER) begin
					mag_nxt = MAG_W'({fold, 1'b0} - {1'b0, HALF});
				end else begin
					neg_nxt = 1'b1;
					mag_nxt = MAG_W'({1'b0, HALF} - {fold, 1'b0});
				end
			end
			WAVE_SAW: begin
				neg_nxt = (f < HALF);
				mag_nxt = fold;
			end
			WAVE_SQUARE: begin
				neg_nxt = !(mod_zero || din.half_lt);
				mag_nxt = HALF;
			end
			WAVE_PULSE: begin
				neg_nxt = !(mod_zero || din.fifth_lt);
				mag_nxt = HALF;
			end
			default: begin
				neg_nxt = 1'b0;
				mag_nxt = '0;
			end
		endcase
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= din.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// wave, product, rounding and mix registers
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= neg_nxt;
			mag_s1  <= mag_nxt;
			mix_s1  <= din.mix;

			neg_s2  <= neg_s1;
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(cfg.gain);
			mix_s2  <= mix_s1;

			neg_s3  <= neg_s2;
			sc_s3   <= sc_nxt;
			mix_s3  <= mix_s2;

			mix_s4  <= sat_nxt;
		end
	end

	// round to nearest, halves away from zero on the magnitude
	assign rnd_sum = {1'b0, prod_s2} + RND;
	assign sc_nxt  = rnd_sum[PROD_W:SCALE_SHIFT];

	// add onto the mix sample and saturate
	always_comb begin
		mix_x = {{(SUM_W-SAMPLE_W){mix_s3[SAMPLE_W-1]}}, mix_s3};
		add_x = {{(SUM_W-SC_W){1'b0}}, sc_s3};
		if (neg_s3) begin
			add_x = -add_x;
		end
		sum = mix_x + add_x;
		if (sum > SAT_HI) begin
			sat_nxt = SAT_HI[SAMPLE_W-1:0];
		end else if (sum < SAT_LO) begin
			sat_nxt = SAT_LO[SAMPLE_W-1:0];
		end else begin
			sat_nxt = sum[SAMPLE_W-1:0];
		end
	end

	assign vld     = vld_s4;
	assign mix_out = mix_s4;

endmodule

// ===== src/mwom_obuf.sv =====
// ----------------------------------------------------------------------------
// mwom_obuf
// Two entry output buffer; the pipeline advances whenever a slot is free, so
// the downstream ready never reaches the upstream side.
// ----------------------------------------------------------------------------
module mwom_obuf import mwom_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [SAMPLE_W-1:0] push_data,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] mix_out
);

	logic [1:0]          count_q;
	logic [SAMPLE_W-1:0] head_q;
	logic [SAMPLE_W-1:0] tail_q;
	logic                pop;

	assign space     = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign mix_out   = head_q;

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// hold results in order, head first
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1) begin
				head_q <= push_data;
			end else begin
				head_q <= tail_q;
			end
			if (push && count_q == 2'd2) begin
				tail_q <= push_data;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end
	end

endmodule

// ===== src/multi_waveform_oscillator_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_mixer_unit
// Naive triangle, saw, square and pulse oscillator added onto a mix stream.
// ----------------------------------------------------------------------------
// One request per clock is taken and one result per clock is delivered in
// steady state. A request's result is offered on out_valid after it passes, in
// order, the numerator register loaded at the accepting edge, a 75 stage long
// division that yields one quotient bit per stage (51 for the phase remainder,
// 24 for the phase fraction), four stages of wave shaping, gain multiply,
// rounding and saturation, and a two entry output buffer. The whole pipeline
// stalls only while that buffer is full. Configuration is taken at any time on
// its own port but must only be changed while no request is in flight.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator_mixer_unit import mwom_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [IDX_W-1:0]      sample_index,
	input  logic [SAMPLE_W-1:0]   mix_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SAMPLE_W-1:0]   mix_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mwom_cfg_t           cfg;
	mwom_div_t           div_out;
	logic                en;
	logic                mix_vld;
	logic [SAMPLE_W-1:0] mix_data;

	// accept requests whenever the pipeline advances
	assign in_ready = en;

	mwom_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mwom_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cfg          (cfg),
		.in_vld       (in_valid),
		.sample_index (sample_index),
		.mix_in       (mix_in),
		.dout         (div_out)
	);

	mwom_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg),
		.din     (div_out),
		.vld     (mix_vld),
		.mix_out (mix_data)
	);

	mwom_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && mix_vld),
		.push_data (mix_data),
		.space     (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mix_out   (mix_out)
	);

endmodule
